[sv/dsd_pkg.sv]
package dsd_pkg;

  localparam int unsigned InW  = 48;
  localparam int unsigned OutW = 56;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // Day-number constants
  localparam int JdnOff     = 2415019 + 32075;
  localparam int WdOff      = 2415019 + 1;
  localparam int LBase      = 68569 + 2415019;
  localparam int SerialMin  = -693594;
  localparam int SerialMax  = 2958465;
  localparam int PhantomSer = 60;

  // Reciprocals floor(2^k / c) for constant division
  localparam int unsigned Rec100  = (1 << 14) / 100;
  localparam int unsigned Rec7    = (1 << 23) / 7;
  localparam int unsigned Rec146k = (1 << 25) / 146097;
  localparam int unsigned Rec1461k = (1 << 28) / 1461001;
  localparam int unsigned Rec2447 = (1 << 15) / 2447;
  localparam int unsigned Rec80   = (1 << 15) / 80;

  typedef struct packed {
    logic signed [22:0] day_offset;
    logic [13:0]        in_year;
    logic [3:0]         in_month;
    logic [4:0]         in_day;
  } in_t;

  typedef struct packed {
    logic               out_in_range;
    logic [13:0]        out_year;
    logic [3:0]         out_month;
    logic [4:0]         out_day;
    logic               month_end;
    logic [2:0]         week_day;
    logic signed [22:0] serial_day;
    logic               date_ok;
  } out_t;

  // Word passed from front to back
  typedef struct packed {
    logic               ok;
    logic signed [22:0] serial;
    logic [2:0]         wd;
    logic               mend;
    logic signed [22:0] off;
  } fr_item_t;

  // (367 * (m - 2 + 12a)) / 12 for m = 1..12
  function automatic logic [8:0] month_term(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd336;
      4'd2:    r = 9'd367;
      4'd3:    r = 9'd30;
      4'd4:    r = 9'd61;
      4'd5:    r = 9'd91;
      4'd6:    r = 9'd122;
      4'd7:    r = 9'd152;
      4'd8:    r = 9'd183;
      4'd9:    r = 9'd214;
      4'd10:   r = 9'd244;
      4'd11:   r = 9'd275;
      4'd12:   r = 9'd305;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2:                      r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

[sv/dsd_front.sv]
module dsd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_vld_i,
  input  dsd_pkg::in_t      in_data_i,
  output logic              out_vld_o,
  output dsd_pkg::fr_item_t out_item_o
);
  import dsd_pkg::*;

  logic [5:0] vld_q;

  // stage 0: captured word
  in_t in0_q;

  // stage 1: validate, prepare terms
  logic [21:0] py;
  logic [7:0]  qy_e, qy;
  logic [14:0] ry_e;
  logic [6:0]  ry;
  logic        leap, ok1;
  logic        a_n;
  logic        ok1_q, mend1_q;
  logic [4:0]  d1_q;
  logic [13:0] yy1_q, zz1_q;
  logic [8:0]  t2_1_q;
  logic signed [22:0] off1_q;

  // stage 2
  logic [22:0] t1_2_q;
  logic [21:0] pz2_q;
  logic [13:0] zz2_q;
  logic [8:0]  t2_2_q;
  logic [4:0]  d2_q;
  logic        ok2_q, mend2_q;
  logic signed [22:0] off2_q;

  // stage 3
  logic [7:0]  qz_e, qz;
  logic [14:0] rz_e;
  logic [6:0]  t3;
  logic [23:0] raw3_q;
  logic        ok3_q, mend3_q;
  logic signed [22:0] off3_q;

  // stage 4
  logic [23:0] xw;
  logic [22:0] x4_q;
  logic [42:0] pw4_q;
  logic signed [22:0] ser4_q;
  logic        ok4_q, mend4_q;
  logic signed [22:0] off4_q;

  // stage 5
  logic [19:0] q7;
  logic [22:0] r7;
  fr_item_t    item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], in_vld_i};
    end
  end

  // year / 100 for the leap rule, then the date check and the early-month flag
  always_comb begin
    py   = 22'(in0_q.in_year) * 22'(Rec100);
    qy_e = py[21:14];
    ry_e = 15'(in0_q.in_year) - 15'(qy_e) * 15'd100;
    qy   = (ry_e >= 15'd100) ? qy_e + 8'd1 : qy_e;
    ry   = (ry_e >= 15'd100) ? 7'(ry_e - 15'd100) : 7'(ry_e);
    leap = ((in0_q.in_year[1:0] == 2'd0) && (ry != 7'd0)) ||
           ((ry == 7'd0) && (qy[1:0] == 2'd0));
    ok1  = 1'b1;
    if (in0_q.in_day < 5'd1 || in0_q.in_month < 4'd1 || in0_q.in_month > 4'd12 ||
        in0_q.in_year < 14'd1 || in0_q.in_year > 14'd9999) begin
      ok1 = 1'b0;
    end else if (in0_q.in_day > month_len(in0_q.in_month, leap)) begin
      ok1 = 1'b0;
    end
    a_n = (in0_q.in_month <= 4'd2);
  end

  always_comb begin
    qz_e = pz2_q[21:14];
    rz_e = 15'(zz2_q) - 15'(qz_e) * 15'd100;
    qz   = (rz_e >= 15'd100) ? qz_e + 8'd1 : qz_e;
    t3   = 7'((10'(qz) * 10'd3) >> 2);
  end

  always_comb begin
    xw = raw3_q + 24'(WdOff);
  end

  always_comb begin
    q7 = pw4_q[42:23];
    r7 = x4_q - 23'(q7) * 23'd7;
    if (r7 >= 23'd7) begin
      r7 = r7 - 23'd7;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in0_q <= in_data_i;

      ok1_q   <= ok1;
      // the phantom leap day means Feb 28 1900 has no month end
      mend1_q <= (in0_q.in_day == month_len(in0_q.in_month, leap)) &&
                 !(in0_q.in_year == 14'd1900 && in0_q.in_month == 4'd2);
      d1_q    <= in0_q.in_day;
      yy1_q   <= in0_q.in_year + 14'd4800 - 14'(a_n);
      zz1_q   <= in0_q.in_year + 14'd4900 - 14'(a_n);
      t2_1_q  <= month_term(in0_q.in_month);
      off1_q  <= in0_q.day_offset;

      t1_2_q  <= 23'((25'(yy1_q) * 25'd1461) >> 2);
      pz2_q   <= 22'(zz1_q) * 22'(Rec100);
      zz2_q   <= zz1_q;
      t2_2_q  <= t2_1_q;
      d2_q    <= d1_q;
      ok2_q   <= ok1_q;
      mend2_q <= mend1_q;
      off2_q  <= off1_q;

      raw3_q  <= 24'(t1_2_q) + 24'(t2_2_q) - 24'(t3) + 24'(d2_q) - 24'(JdnOff);
      ok3_q   <= ok2_q;
      mend3_q <= mend2_q;
      off3_q  <= off2_q;

      x4_q    <= xw[22:0];
      pw4_q   <= 43'(xw[22:0]) * 43'(Rec7);
      ser4_q  <= ($signed(raw3_q) <= 24'sd60) ? 23'(raw3_q - 24'd1) : 23'(raw3_q);
      ok4_q   <= ok3_q;
      mend4_q <= mend3_q;
      off4_q  <= off3_q;

      item_q.ok     <= ok4_q;
      item_q.serial <= ser4_q;
      item_q.wd     <= r7[2:0];
      item_q.mend   <= mend4_q;
      item_q.off    <= off4_q;
    end
  end

  assign out_vld_o  = vld_q[5];
  assign out_item_o = item_q;

endmodule

[sv/dsd_fifo.sv]
module dsd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dsd_pkg::fr_item_t push_data_i,
  input  logic              pop_i,
  output dsd_pkg::fr_item_t pop_data_o,
  output logic              full_o,
  output logic              empty_o
);
  import dsd_pkg::*;

  fr_item_t          mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_q, rd_q;
  logic [FifoAw:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (FifoAw+1)'(push_i) - (FifoAw+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_q];
  assign full_o     = (cnt_q == (FifoAw+1)'(FifoDepth));
  assign empty_o    = (cnt_q == '0);

endmodule

[sv/dsd_back.sv]
module dsd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_vld_i,
  input  dsd_pkg::fr_item_t in_item_i,
  output logic              out_vld_o,
  output dsd_pkg::out_t     out_data_o
);
  import dsd_pkg::*;

  localparam int unsigned NStg = 12;

  typedef struct packed {
    fr_item_t           it;
    logic signed [23:0] t;
    logic               inr;
    logic               sp60;
    logic [22:0]        l;
    logic [36:0]        p;
    logic [7:0]         n;
    logic [15:0]        l2;
    logic [27:0]        x4;
    logic [6:0]         i;
    logic [8:0]         l3;
    logic [3:0]         j;
    logic [14:0]        pd;
    logic [4:0]         dd;
    logic [3:0]         mm;
    logic [13:0]        yy;
    logic               kk;
  } bst_t;

  bst_t              st_q [NStg-1];
  bst_t              st_d [NStg-1];
  logic [NStg-1:0]   vld_q;
  out_t              out_q, out_d;

  logic signed [23:0] s1;
  logic [23:0]        ls1;
  logic [7:0]         n_e;
  logic [25:0]        rn;
  logic [8:0]         i_e;
  logic [27:0]        ri;
  logic [4:0]         j_e;
  logic [14:0]        rj;
  logic [8:0]         qd_e, qd;
  logic [14:0]        rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NStg-2:0], in_vld_i};
    end
  end

  always_comb begin
    for (int k = 1; k < NStg - 1; k++) begin
      st_d[k] = st_q[k-1];
    end
    st_d[0]    = '0;
    st_d[0].it = in_item_i;

    // offset serial and range check
    st_d[1].t    = $signed({st_q[0].it.serial[22], st_q[0].it.serial}) +
                   $signed({st_q[0].it.off[22], st_q[0].it.off});
    st_d[1].inr  = (st_d[1].t >= $signed(24'(SerialMin))) &&
                   (st_d[1].t <= $signed(24'(SerialMax)));
    st_d[1].sp60 = (st_d[1].t == 24'sd60);

    // undo the phantom day, move to day number
    s1  = (st_q[1].t < 24'sd60) ? st_q[1].t + 24'sd1 : st_q[1].t;
    ls1 = s1 + 24'(LBase);
    st_d[2].l = ls1[22:0];
    st_d[2].p = 37'(ls1[22:0]) * 37'(4 * Rec146k);

    // n = 4l / 146097
    n_e = st_q[2].p[32:25];
    rn  = {1'b0, st_q[2].l, 2'b00} - 26'(n_e) * 26'd146097;
    st_d[3].n = (rn >= 26'd146097) ? n_e + 8'd1 : n_e;

    st_d[4].l2 = 16'(st_q[3].l - 23'((25'(st_q[3].n) * 25'd146097 + 25'd3) >> 2));

    st_d[5].x4 = 28'(st_q[4].l2 + 16'd1) * 28'd4000;
    st_d[5].p  = 37'(st_q[4].l2 + 16'd1) * 37'(4000 * Rec1461k);

    // i = 4000 (l + 1) / 1461001
    i_e = st_q[5].p[36:28];
    ri  = st_q[5].x4 - 28'(i_e) * 28'd1461001;
    st_d[6].i = (ri >= 28'd1461001) ? 7'(i_e + 9'd1) : 7'(i_e);

    st_d[7].l3 = 9'(st_q[6].l2 - 16'((18'(st_q[6].i) * 18'd1461) >> 2) + 16'd31);
    st_d[7].p  = 37'(st_q[6].l2 - 16'((18'(st_q[6].i) * 18'd1461) >> 2) + 16'd31) *
                 37'(80 * Rec2447);

    // j = 80 l / 2447
    j_e = st_q[7].p[19:15];
    rj  = 15'(st_q[7].l3) * 15'd80 - 15'(j_e) * 15'd2447;
    st_d[8].j = (rj >= 15'd2447) ? 4'(j_e + 5'd1) : 4'(j_e);

    st_d[9].pd = 15'(st_q[8].j) * 15'd2447;
    st_d[9].kk = (st_q[8].j >= 4'd11);
    st_d[9].mm = st_q[8].j + 4'd2 - (st_d[9].kk ? 4'd12 : 4'd0);
    st_d[9].yy = 14'(st_q[8].n - 8'd49) * 14'd100 + 14'(st_q[8].i) + 14'(st_d[9].kk);
    st_d[9].p  = 37'(15'(st_q[8].j) * 15'd2447) * 37'(Rec80);

    // day = l - 2447 j / 80
    qd_e = st_q[9].p[23:15];
    rd   = st_q[9].pd - 15'(qd_e) * 15'd80;
    qd   = (rd >= 15'd80) ? qd_e + 9'd1 : qd_e;
    st_d[10].dd = 5'(st_q[9].l3 - qd);

    out_d = '0;
    if (st_q[10].it.ok) begin
      out_d.date_ok    = 1'b1;
      out_d.serial_day = st_q[10].it.serial;
      out_d.week_day   = st_q[10].it.wd;
      out_d.month_end  = st_q[10].it.mend;
      if (st_q[10].inr) begin
        out_d.out_in_range = 1'b1;
        if (st_q[10].sp60) begin
          out_d.out_day   = 5'd29;
          out_d.out_month = 4'd2;
          out_d.out_year  = 14'd1900;
        end else begin
          out_d.out_day   = st_q[10].dd;
          out_d.out_month = st_q[10].mm;
          out_d.out_year  = st_q[10].yy;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NStg - 1; k++) begin
        st_q[k] <= st_d[k];
      end
      out_q <= out_d;
    end
  end

  assign out_vld_o  = vld_q[NStg-1];
  assign out_data_o = out_q;

endmodule

[sv/date_serial_and_day_offset.sv]
// Stages from an accepted input word to its result word (6 front stages,
// 1 queue, 12 back stages). Throughput: one word per cycle unless the output
// stalls; set by the pipelined constant dividers.
// A 4-entry queue lets the front keep taking words while the output stalls.
// Reset (rst_ni low, asynchronous) empties the pipelines and the queue.
module date_serial_and_day_offset (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // in_day[4:0], in_month[8:5], in_year[22:9], day_offset[45:23], zero pad
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // date_ok[0], serial_day[23:1], week_day[26:24], month_end[27],
  // out_day[32:28], out_month[36:33], out_year[50:37], out_in_range[51], zero pad
  output logic [55:0] m_axis_tdata_o
);
  import dsd_pkg::*;

  logic     fr_en, fr_vld, bk_en, fifo_full, fifo_empty, push, pop, bk_vld;
  fr_item_t fr_item, q_item;
  in_t      in_word;
  out_t     out_word;

  assign in_word = in_t'(s_axis_tdata_i[$bits(in_t)-1:0]);

  // hold the front only when its last word cannot enter the queue
  assign fr_en = !(fr_vld && fifo_full);
  assign push  = fr_vld && fr_en;
  assign bk_en = !(bk_vld && !m_axis_tready_i);
  assign pop   = bk_en && !fifo_empty;

  dsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (fr_en),
    .in_vld_i   (s_axis_tvalid_i),
    .in_data_i  (in_word),
    .out_vld_o  (fr_vld),
    .out_item_o (fr_item)
  );

  dsd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (fr_item),
    .pop_i       (pop),
    .pop_data_o  (q_item),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty)
  );

  dsd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (bk_en),
    .in_vld_i   (pop),
    .in_item_i  (q_item),
    .out_vld_o  (bk_vld),
    .out_data_o (out_word)
  );

  assign s_axis_tready_o = fr_en;
  assign m_axis_tvalid_o = bk_vld;
  assign m_axis_tdata_o  = {(OutW - $bits(out_t))'(0), out_word};

  a_wd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_word.week_day <= 3'd6))
    else $error("weekday out of range");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !out_word.date_ok) |-> (m_axis_tdata_o == '0))
    else $error("invalid date word not zero");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !out_word.out_in_range) |->
      (out_word.out_day == '0 && out_word.out_month == '0 && out_word.out_year == '0))
    else $error("offset date out of range but not zero");

  a_no_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_vld && fifo_full) |-> !s_axis_tready_o)
    else $error("front advanced into a full queue");

endmodule
